// ===== hdl/unix_time_to_civil_datetime_assert.svh =====
// ----------------------------------------------------------------------------
// unix time to civil date: assertion macros
// shared property forms, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef UNIX_TIME_TO_CIVIL_DATETIME_ASSERT_SVH
`define UNIX_TIME_TO_CIVIL_DATETIME_ASSERT_SVH

// same-cycle implication
`define UCD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UCD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ucd_pkg.sv =====
// ----------------------------------------------------------------------------
// ucd_pkg
// types, constants and tables shared by the unix time to civil date pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package ucd_pkg;

	// 86400 = 128 * 675, so the day split divides by 675 after a shift
	localparam logic [9:0]  DAY_DIV_ODD  = 10'd675;
	localparam logic [16:0] DAY_SECONDS  = 17'd86400;
	localparam logic [11:0] HOUR_SECONDS = 12'd3600;
	localparam logic [5:0]  MIN_SECONDS  = 6'd60;
	localparam logic [23:0] DAY_SHIFT    = 24'd719468;
	localparam logic [17:0] ERA_DAYS     = 18'd146097;
	localparam logic [17:0] ERA_LAST_DAY = 18'd146096;
	localparam logic [8:0]  YEAR_DAYS    = 9'd365;

	// reciprocals: ceil(2^k / d), k chosen so the quotient is exact over the input range
	localparam logic [17:0] M_Q1    = 18'(((64'd1 << 27) + 64'd674) / 64'd675);
	localparam logic [26:0] M_Q2    = 27'(((64'd1 << 36) + 64'd674) / 64'd675);
	localparam logic [17:0] M_HOUR  = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
	localparam logic [12:0] M_MIN   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
	localparam logic [24:0] M_ERA   = 25'(((64'd1 << 42) + 64'd146096) / 64'd146097);
	localparam logic [18:0] M_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam logic [18:0] M_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
	localparam logic [18:0] M_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
	localparam logic [11:0] M_153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

	typedef struct packed {
		logic [23:0] days;
		logic [16:0] sod;
	} split_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} tod_t;

	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		tod_t        tod;
	} civil_t;

	// first day of each march-based month within the year
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ucd_day_split.sv =====
// ----------------------------------------------------------------------------
// ucd_day_split
// four-stage pipeline splitting seconds into whole days and second of day
// ----------------------------------------------------------------------------
`default_nettype none
`include "unix_time_to_civil_datetime_assert.svh"

module ucd_day_split (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [39:0]     in_seconds,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output ucd_pkg::split_t      out_data
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [16:0] uh_s1;
	logic [15:0] ul_s1, ul_s2;
	logic [6:0]  lo_s1, lo_s2, lo_s3;
	logic [7:0]  q1_s1, q1_s2, q1_s3;
	logic [9:0]  r1_s2;
	logic [25:0] x2_s3;
	logic [15:0] q2_s3;
	logic [23:0] days_s4;
	logic [16:0] sod_s4;

	logic [34:0] prod1;
	logic [25:0] x2;
	logic [52:0] prod2;
	logic [25:0] rem2;

	assign rdy_s4   = !vld_s4 || out_ready;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// seconds >> 7, upper 17 bits, divided by 675
	assign prod1 = 35'(in_seconds[39:23]) * 35'(ucd_pkg::M_Q1);
	// remainder joined with the lower 16 bits, divided by 675
	assign x2    = {r1_s2, ul_s2};
	assign prod2 = 53'(x2) * 53'(ucd_pkg::M_Q2);
	assign rem2  = x2_s3 - 26'(q2_s3) * 26'(ucd_pkg::DAY_DIV_ODD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			uh_s1 <= in_seconds[39:23];
			ul_s1 <= in_seconds[22:7];
			lo_s1 <= in_seconds[6:0];
			q1_s1 <= prod1[27 +: 8];
		end
		if (rdy_s2 && vld_s1) begin
			r1_s2 <= 10'(uh_s1 - 17'(q1_s1) * 17'(ucd_pkg::DAY_DIV_ODD));
			q1_s2 <= q1_s1;
			ul_s2 <= ul_s1;
			lo_s2 <= lo_s1;
		end
		if (rdy_s3 && vld_s2) begin
			x2_s3 <= x2;
			q2_s3 <= prod2[36 +: 16];
			q1_s3 <= q1_s2;
			lo_s3 <= lo_s2;
		end
		if (rdy_s4 && vld_s3) begin
			days_s4 <= {q1_s3, q2_s3};
			sod_s4  <= {rem2[9:0], lo_s3};
		end
	end

	assign out_valid     = vld_s4;
	assign out_data.days = days_s4;
	assign out_data.sod  = sod_s4;

	`UCD_ASSERT_IMP(a_r1_range, vld_s2, r1_s2 < ucd_pkg::DAY_DIV_ODD, "first remainder too large")
	`UCD_ASSERT_IMP(a_sod_range, vld_s4, sod_s4 < ucd_pkg::DAY_SECONDS, "second of day too large")
	`UCD_ASSERT_NXT(a_s1_hold, vld_s1 && !rdy_s2, vld_s1, "stalled stage dropped its item")

endmodule

`default_nettype wire

// ===== hdl/ucd_civil.sv =====
// ----------------------------------------------------------------------------
// ucd_civil
// nine-stage pipeline: day count to year, month, day; second of day to h:m:s
// ----------------------------------------------------------------------------
`default_nettype none
`include "unix_time_to_civil_datetime_assert.svh"

module ucd_civil (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire ucd_pkg::split_t in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output ucd_pkg::civil_t      out_data
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8, rdy_s9;

	logic [23:0] z_s1, z_s2;
	logic [16:0] sod_s1;
	logic [4:0]  hour_s1, hour_s2, hour_s3;
	logic [6:0]  era_s2, era_s3, era_s4, era_s5, era_s6;
	logic [11:0] rm_s2, rm_s3;
	logic [17:0] doe_s3, doe_s4, doe_s5, doe_s6;
	logic [5:0]  min_s3;
	logic [6:0]  a_s4;
	logic [2:0]  b_s4;
	logic        c_s4;
	logic [17:0] x_s5;
	logic [8:0]  yoe_s6;
	logic [8:0]  doy_s7, doy_s8;
	logic [15:0] ybase_s7, ybase_s8;
	logic [3:0]  mp_s8;
	logic [15:0] year_s9;
	logic [3:0]  month_s9;
	logic [4:0]  day_s9;
	ucd_pkg::tod_t tod_s4, tod_s5, tod_s6, tod_s7, tod_s8, tod_s9;

	logic [34:0] prod_hour;
	logic [48:0] prod_era;
	logic [24:0] prod_min;
	logic [36:0] prod_a, prod_b, prod_yoe;
	logic [23:0] doe_full;
	logic [11:0] sec_full;
	logic [1:0]  cent;
	logic [17:0] yoe_days;
	logic [10:0] mp_num;
	logic [22:0] prod_mp;
	logic [8:0]  dd_full;
	logic [3:0]  mm;

	assign rdy_s9   = !vld_s9 || out_ready;
	assign rdy_s8   = !vld_s8 || rdy_s9;
	assign rdy_s7   = !vld_s7 || rdy_s8;
	assign rdy_s6   = !vld_s6 || rdy_s7;
	assign rdy_s5   = !vld_s5 || rdy_s6;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// time of day
	assign prod_hour = 35'(in_data.sod) * 35'(ucd_pkg::M_HOUR);
	assign prod_min  = 25'(rm_s2) * 25'(ucd_pkg::M_MIN);
	assign sec_full  = rm_s3 - 12'(min_s3) * 12'(ucd_pkg::MIN_SECONDS);

	// era and day of era
	assign prod_era = 49'(z_s1) * 49'(ucd_pkg::M_ERA);
	assign doe_full = z_s2 - 24'(era_s2) * 24'(ucd_pkg::ERA_DAYS);

	// leap corrections inside the era, then year of era
	assign prod_a   = 37'(doe_s3) * 37'(ucd_pkg::M_1460);
	assign prod_b   = 37'(doe_s3) * 37'(ucd_pkg::M_36524);
	assign prod_yoe = 37'(x_s5) * 37'(ucd_pkg::M_365);

	// whole centuries in the year of era, at most three
	always_comb begin
		if (yoe_s6 >= 9'd300)      cent = 2'd3;
		else if (yoe_s6 >= 9'd200) cent = 2'd2;
		else if (yoe_s6 >= 9'd100) cent = 2'd1;
		else                       cent = 2'd0;
	end

	assign yoe_days = 18'(yoe_s6) * 18'(ucd_pkg::YEAR_DAYS) + 18'(yoe_s6[8:2]) - 18'(cent);

	// march-based month index
	assign mp_num  = 11'(doy_s7) * 11'd5 + 11'd2;
	assign prod_mp = 23'(mp_num) * 23'(ucd_pkg::M_153);

	assign dd_full = doy_s8 - ucd_pkg::month_start(mp_s8) + 9'd1;
	assign mm      = (mp_s8 < 4'd10) ? mp_s8 + 4'd3 : mp_s8 - 4'd9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
			if (rdy_s8) vld_s8 <= vld_s7;
			if (rdy_s9) vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			z_s1    <= in_data.days + ucd_pkg::DAY_SHIFT;
			sod_s1  <= in_data.sod;
			hour_s1 <= prod_hour[29 +: 5];
		end
		if (rdy_s2 && vld_s1) begin
			z_s2    <= z_s1;
			era_s2  <= prod_era[42 +: 7];
			hour_s2 <= hour_s1;
			rm_s2   <= 12'(sod_s1 - 17'(hour_s1) * 17'(ucd_pkg::HOUR_SECONDS));
		end
		if (rdy_s3 && vld_s2) begin
			doe_s3  <= doe_full[17:0];
			era_s3  <= era_s2;
			hour_s3 <= hour_s2;
			rm_s3   <= rm_s2;
			min_s3  <= prod_min[18 +: 6];
		end
		if (rdy_s4 && vld_s3) begin
			doe_s4        <= doe_s3;
			era_s4        <= era_s3;
			a_s4          <= prod_a[29 +: 7];
			b_s4          <= prod_b[34 +: 3];
			c_s4          <= (doe_s3 == ucd_pkg::ERA_LAST_DAY);
			tod_s4.hour   <= hour_s3;
			tod_s4.minute <= min_s3;
			tod_s4.second <= sec_full[5:0];
		end
		if (rdy_s5 && vld_s4) begin
			doe_s5 <= doe_s4;
			era_s5 <= era_s4;
			x_s5   <= doe_s4 - 18'(a_s4) + 18'(b_s4) - 18'(c_s4);
			tod_s5 <= tod_s4;
		end
		if (rdy_s6 && vld_s5) begin
			doe_s6 <= doe_s5;
			era_s6 <= era_s5;
			yoe_s6 <= prod_yoe[27 +: 9];
			tod_s6 <= tod_s5;
		end
		if (rdy_s7 && vld_s6) begin
			doy_s7   <= 9'(doe_s6 - yoe_days);
			ybase_s7 <= 16'(era_s6) * 16'd400 + 16'(yoe_s6);
			tod_s7   <= tod_s6;
		end
		if (rdy_s8 && vld_s7) begin
			doy_s8   <= doy_s7;
			mp_s8    <= prod_mp[19 +: 4];
			ybase_s8 <= ybase_s7;
			tod_s8   <= tod_s7;
		end
		if (rdy_s9 && vld_s8) begin
			// january and february belong to the next calendar year
			year_s9  <= ybase_s8 + 16'(mm <= 4'd2);
			month_s9 <= mm;
			day_s9   <= dd_full[4:0];
			tod_s9   <= tod_s8;
		end
	end

	assign out_valid      = vld_s9;
	assign out_data.year  = year_s9;
	assign out_data.month = month_s9;
	assign out_data.day   = day_s9;
	assign out_data.tod   = tod_s9;

	`UCD_ASSERT_IMP(a_doe_range, vld_s3, doe_s3 < ucd_pkg::ERA_DAYS, "day of era out of range")
	`UCD_ASSERT_IMP(a_doy_range, vld_s7, doy_s7 < 9'd366, "day of year out of range")
	`UCD_ASSERT_IMP(a_tod_range, vld_s4, (tod_s4.hour < 5'd24) && (tod_s4.minute < 6'd60) && (tod_s4.second < 6'd60), "time of day out of range")

endmodule

`default_nettype wire

// ===== hdl/unix_time_to_civil_datetime.sv =====
// ----------------------------------------------------------------------------
// unix_time_to_civil_datetime
// converts seconds since 1970-01-01 utc to gregorian date and time of day
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one 40-bit unsigned second count per transfer; m_axis
//   returns one transfer per input with year, month, day, hour, minute and
//   second, in input order.
//   the path is a 13-stage pipeline: 4 stages split off whole days and the
//   second of day (division by 86400 as a shift and two reciprocal products),
//   9 stages work out era, year of era, day of year and month while the time
//   of day is split alongside. one transfer is taken every cycle while
//   m_axis keeps taking results.
//   each stage holds its own valid bit and is ready when empty or when the
//   stage after it moves, so bubbles close up and inputs keep flowing while
//   a result waits on m_axis.
//   when m_axis_tready stays low the pipeline fills and s_axis_tready drops
//   after the empty stages are used; no transfer is lost or repeated.
//   arst_n empties every stage; there is no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module unix_time_to_civil_datetime (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // [39:0] unix_seconds
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [15:0] year, [19:16] month, [24:20] day, [29:25] hour,
	// [35:30] minute, [41:36] second, [47:42] zero
	output logic [47:0]      m_axis_tdata
);

	ucd_pkg::split_t split_data;
	ucd_pkg::civil_t civil_data;
	logic            split_valid;
	logic            split_ready;

	ucd_day_split u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_seconds (s_axis_tdata),
		.out_valid  (split_valid),
		.out_ready  (split_ready),
		.out_data   (split_data)
	);

	ucd_civil u_civil (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (split_valid),
		.in_ready  (split_ready),
		.in_data   (split_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (civil_data)
	);

	assign m_axis_tdata = {6'd0, civil_data.tod.second, civil_data.tod.minute,
		civil_data.tod.hour, civil_data.day, civil_data.month, civil_data.year};

endmodule

`default_nettype wire

// ===== tb/sv/tb_unix_time_to_civil_datetime.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unix_time_to_civil_datetime
// streams second counts into the converter and checks every returned date and
// time of day against a bench calendar model or a written-out date; both stream
// sides idle and stall at random, a short table of calendar edges comes first
// ----------------------------------------------------------------------------

module tb_unix_time_to_civil_datetime;

	localparam int CLK_HALF    = 6;
	localparam int RESET_TICKS = 4;
	localparam int DIR_ROWS    = 22;
	localparam int RAND_ITEMS  = 600;
	localparam int LATENCY     = 13;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX  = 10;
	localparam int SRC         = 0;
	localparam int SNK         = 1;

	// last day whose final second still fits in 40 bits
	localparam int unsigned LAST_FULL_DAY = 12725828;
	// days from 0000-03-01 to 1970-01-01, and days in a 400-year cycle
	localparam longint unsigned EPOCH_SHIFT = 719468;
	localparam longint unsigned CYCLE_DAYS  = 146097;
	localparam longint unsigned DAY_SECS    = 86400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // [39:0] unix_seconds
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [15:0] year, [19:16] month, [24:20] day, [29:25] hour,
	// [35:30] minute, [41:36] second, [47:42] zero
	logic [47:0] m_axis_tdata;

	logic [47:0] pending_dates[$];
	logic [47:0] typed_date = '0;
	int          run_left[2] = '{0, 0};
	bit          calm[2] = '{0, 0};
	int          mismatches = 0;
	int          sent = 0;
	int          checked = 0;
	int          cycles = 0;

	unix_time_to_civil_datetime dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #CLK_HALF clk = ~clk;

	// date and time of day packed as on m_axis_tdata
	function automatic logic [47:0] civil_from_unix(input logic [39:0] secs);
		longint unsigned t, ss, mi, hh, shifted, era, doe, yoe, doy, mp, dom, mon, yr;
		t = secs;
		ss = t % 60;
		t = t / 60;
		mi = t % 60;
		t = t / 60;
		hh = t % 24;
		t = t / 24;
		shifted = t + EPOCH_SHIFT;
		era = shifted / CYCLE_DAYS;
		doe = shifted - era * CYCLE_DAYS;
		// strip leap days before dividing into years of the cycle
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		// month index counts from march
		mp = (5 * doy + 2) / 153;
		dom = doy - (153 * mp + 2) / 5 + 1;
		mon = (mp < 10) ? mp + 3 : mp - 9;
		yr = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
		return {6'd0, ss[5:0], mi[5:0], hh[4:0], dom[4:0], mon[3:0], yr[15:0]};
	endfunction

	// calendar edges; upper 48 bits hold a written-out date, zero where the model decides
	function automatic logic [87:0] edge_row(input int i);
		logic [39:0] secs;
		logic [47:0] want;
		want = '0;
		case (i)
			0: begin
				secs = 40'd0;
				want = {6'd0, 6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 16'd1970};
			end
			1: begin
				secs = 40'd59;
				want = {6'd0, 6'd59, 6'd0, 5'd0, 5'd1, 4'd1, 16'd1970};
			end
			2: begin
				secs = 40'd3599;
				want = {6'd0, 6'd59, 6'd59, 5'd0, 5'd1, 4'd1, 16'd1970};
			end
			3: begin
				secs = 40'd86399;
				want = {6'd0, 6'd59, 6'd59, 5'd23, 5'd1, 4'd1, 16'd1970};
			end
			4: begin
				secs = 40'd86400;
				want = {6'd0, 6'd0, 6'd0, 5'd0, 5'd2, 4'd1, 16'd1970};
			end
			5:  secs = 40'd31535999;      // end of the first year
			6:  secs = 40'd68169600;      // leap day, ordinary leap year
			7:  secs = 40'd946684799;     // year rollover
			8:  secs = 40'd946684800;
			9:  secs = 40'd951782400;     // leap day of a year divisible by 400
			10: secs = 40'd951868799;     // last second of a 400-year cycle
			11: secs = 40'd951868800;     // first day of a new cycle
			12: secs = 40'd2147483647;
			13: secs = 40'd4102444799;
			14: secs = 40'd4107542400;    // century year without a leap day
			15: secs = 40'd4294967295;
			16: secs = 40'd253402300799;  // four to five digit year
			17: secs = 40'd253402300800;
			18: secs = 40'h5555555555;
			19: secs = 40'hAAAAAAAAAA;
			20: secs = 40'hFFFFFFFFFE;
			21: begin
				secs = 40'hFFFFFFFFFF;
				want = {6'd0, 6'd15, 6'd36, 5'd0, 5'd20, 4'd2, 16'd36812};
			end
			default: secs = 40'd0;
		endcase
		return {want, secs};
	endfunction

	function automatic logic [39:0] pick_seconds();
		longint unsigned days, sod, wide;
		days = 0;
		case ($urandom_range(0, 3))
			0: wide = {$urandom(), $urandom()};
			1: wide = $urandom();
			2: days = $urandom_range(0, LAST_FULL_DAY);
			default: begin
				// near march 1st, new year, century and cycle ends
				days = longint'($urandom_range(5, 91)) * CYCLE_DAYS
					+ longint'($urandom_range(0, 3)) * 36524
					+ longint'($urandom_range(0, 24)) * 1461
					+ longint'($urandom_range(0, 3)) * 365
					+ longint'($urandom_range(0, 1)) * 305
					+ longint'($urandom_range(0, 4)) - 2 - EPOCH_SHIFT;
			end
		endcase
		if (days != 0) begin
			case ($urandom_range(0, 3))
				0: sod = 0;
				1: sod = DAY_SECS - 1;
				2: sod = DAY_SECS - 1 - $urandom_range(0, 3600);
				default: sod = $urandom_range(0, DAY_SECS - 1);
			endcase
			wide = days * DAY_SECS + sod;
		end
		return wide[39:0];
	endfunction

	// spells of no waiting and spells of random waits follow in random order
	function automatic int next_wait(input int side);
		if (run_left[side] == 0) begin
			run_left[side] = $urandom_range(4, 40);
			calm[side] = ($urandom_range(0, 3) == 0);
		end
		run_left[side]--;
		return calm[side] ? 0 : $urandom_range(0, 14);
	endfunction

	task automatic flag(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got)
			flag($sformatf("%s expected %0d, got %0d", name, want, got));
	endtask

	task automatic send_seconds(input logic [39:0] secs, input logic [47:0] want);
		int gap;
		gap = next_wait(SRC);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= secs;
		typed_date = want;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
		@(negedge clk);
	endtask

	// result side: stall drawn per transfer
	initial begin
		int stall;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = next_wait(SNK);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : watch_transfers
		logic [47:0] want;
		logic [47:0] got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				pending_dates.push_back(typed_date != '0 ? typed_date
					: civil_from_unix(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (pending_dates.size() == 0) begin
					flag($sformatf("result %h with nothing outstanding", got));
				end else begin
					want = pending_dates.pop_front();
					checked++;
					check_field("year",   want[15:0],  got[15:0]);
					check_field("month",  want[19:16], got[19:16]);
					check_field("day",    want[24:20], got[24:20]);
					check_field("hour",   want[29:25], got[29:25]);
					check_field("minute", want[35:30], got[35:30]);
					check_field("second", want[41:36], got[41:36]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timed out with %0d results outstanding", pending_dates.size());
			$display("unix_time_to_civil_datetime: mismatch");
			$finish;
		end
	end

	initial begin
		logic [87:0] row;
		repeat (RESET_TICKS) @(negedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = edge_row(i);
			send_seconds(row[39:0], row[87:40]);
		end
		for (int i = 0; i < RAND_ITEMS; i++)
			send_seconds(pick_seconds(), '0);
		s_axis_tvalid <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		$display("%0d second counts sent (%0d calendar edges, rest random over 40 bits),",
			sent, DIR_ROWS);
		$display("%0d dates checked, %0d field mismatches", checked, mismatches);
		if (mismatches == 0) begin
			$display("unix_time_to_civil_datetime: match");
		end else begin
			$display("unix_time_to_civil_datetime: mismatch");
		end
		$finish;
	end

endmodule
